// ----- sv/ddo_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and constants of the differential drive odometry
// widths, register indexes, operation codes and the cordic arctangent table
// ----------------------------------------------------------------------------
package ddo_pkg;

   localparam int ANGLE_W   = 32;   // binary angle, full turn is 2^32
   localparam int POS_W     = 32;   // signed q16.16 metres
   localparam int TICK_W    = 16;   // signed wheel tick delta
   localparam int CFG_W     = 24;   // widest configuration register
   localparam int CFG_IDX_W = 1;    // two registers
   localparam int OP_W      = 1;

   localparam int CORDIC_ITER_DEFAULT = 24;
   localparam int ATAN_DEPTH          = 32;
   localparam int ATAN_AW             = $clog2(ATAN_DEPTH);

   localparam int CS_W   = 34;      // cordic x/y datapath, q2.30 plus headroom
   localparam int Z_W    = 32;      // residual angle
   localparam int MUL_W  = 33;      // operand width of the shared multiplier
   localparam int PROD_W = 2 * MUL_W;
   localparam int D_W    = 33;      // step distance, signed q16.16
   localparam int UPD_W  = POS_W + 2;

   localparam int D_SHIFT   = 9;    // q0.24 ticks to q16.16
   localparam int ROT_SHIFT = 30;   // q2.30 cos/sin

   localparam logic signed [CS_W-1:0] CORDIC_GAIN = CS_W'(652032874);

   typedef logic [ANGLE_W-1:0]        angle_type;
   typedef logic signed [POS_W-1:0]   pos_type;
   typedef logic signed [TICK_W-1:0]  tick_type;
   typedef logic [CFG_W-1:0]          cfg_type;
   typedef logic [CFG_IDX_W-1:0]      cfg_idx_type;

   localparam cfg_idx_type REG_ANGLE_PER_TICK    = 1'd0;
   localparam cfg_idx_type REG_DISTANCE_PER_TICK = 1'd1;

   localparam logic [OP_W-1:0] OP_ENCODER    = 1'b0;
   localparam logic [OP_W-1:0] OP_CORRECTION = 1'b1;

   // round(atan(2^-i) * 2^32 / 2pi)
   function automatic angle_type atan_lookup(input logic [ATAN_AW-1:0] idx);
      angle_type val;
      unique case (idx)
         5'd0:  val = 32'h20000000;
         5'd1:  val = 32'h12E4051E;
         5'd2:  val = 32'h09FB385B;
         5'd3:  val = 32'h051111D4;
         5'd4:  val = 32'h028B0D43;
         5'd5:  val = 32'h0145D7E1;
         5'd6:  val = 32'h00A2F61E;
         5'd7:  val = 32'h00517C55;
         5'd8:  val = 32'h0028BE53;
         5'd9:  val = 32'h00145F2F;
         5'd10: val = 32'h000A2F98;
         5'd11: val = 32'h000517CC;
         5'd12: val = 32'h00028BE6;
         5'd13: val = 32'h000145F3;
         5'd14: val = 32'h0000A2FA;
         5'd15: val = 32'h0000517D;
         5'd16: val = 32'h000028BE;
         5'd17: val = 32'h0000145F;
         5'd18: val = 32'h00000A30;
         5'd19: val = 32'h00000518;
         5'd20: val = 32'h0000028C;
         5'd21: val = 32'h00000146;
         5'd22: val = 32'h000000A3;
         5'd23: val = 32'h00000051;
         5'd24: val = 32'h00000029;
         5'd25: val = 32'h00000014;
         5'd26: val = 32'h0000000A;
         5'd27: val = 32'h00000005;
         5'd28: val = 32'h00000003;
         5'd29: val = 32'h00000001;
         5'd30: val = 32'h00000001;
         default: val = 32'h00000000;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

// ----- sv/differential_drive_odometry.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// differential_drive_odometry: dead-reckoning pose tracker for a two-wheel robot
// heading update, mean-distance scaling, iterative cordic and saturating x/y
// ----------------------------------------------------------------------------
// An encoder item (operation 0) advances the heading by (left - right) times
// angle_per_tick, wrapping as a binary angle, then moves x and y back by the
// mean tick distance times cos and sin of the new heading, saturating at the
// signed 32-bit limits, and returns one pose item. A correction item
// (operation 1) overwrites the heading and returns nothing.
// The block works on one item at a time: req_tready is high only in idle.
// An encoder item occupies the datapath through the rotation loop of the
// cordic, which does one micro-rotation per cycle, and through the single
// shared multiplier that serves the heading, distance and x/y products in
// turn. The finished pose sits in an output register, so a new item may be
// taken while it waits; the next pose is held back only if the previous one
// is still not taken.
// The user must write registers over csr_* only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module differential_drive_odometry #(
   parameter int CORDIC_ITERATIONS = ddo_pkg::CORDIC_ITER_DEFAULT
) (
   input  wire                          clock,
   input  wire                          reset,
   // input items
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [63:0]                  req_tdata,   // left_ticks, right_ticks, heading_set
   input  wire  [0:0]                   req_tuser,   // operation
   // result items
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [95:0]                  rsp_tdata,   // pos_x, pos_y, heading_out
   // configuration
   input  wire                          csr_wr_en,
   input  wire  [ddo_pkg::CFG_IDX_W-1:0] csr_index,
   input  wire  [ddo_pkg::CFG_W-1:0]    csr_wr_data
);
   import ddo_pkg::*;

   localparam int ITER_W = $clog2(CORDIC_ITERATIONS);
   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERATIONS - 1);

   typedef enum logic [3:0] {
      ST_IDLE,    // wait for an item
      ST_HEAD,    // diff * angle_per_tick
      ST_DIST,    // heading add, sum * distance_per_tick
      ST_INIT,    // round distance, seed the cordic
      ST_ITER,    // one micro-rotation per cycle
      ST_ROT,     // quadrant fix-up
      ST_MULX,    // d * cos
      ST_RNDX,
      ST_UPDX,    // saturating x update
      ST_MULY,    // d * sin
      ST_RNDY,
      ST_UPDY,    // saturating y update
      ST_OUT      // hand pose to the output register
   } state_type;

   // control state
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   cfg_type   apt_ff, apt_in;
   cfg_type   dpt_ff, dpt_in;
   angle_type heading_ff, heading_in;
   pos_type   pos_x_ff, pos_x_in;
   pos_type   pos_y_ff, pos_y_in;

   // datapath registers
   logic signed [TICK_W:0]    diff_ff, diff_in;
   logic signed [TICK_W:0]    sum_ff, sum_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [D_W-1:0]     d_ff, d_in;
   logic signed [CS_W-1:0]    c_ff, c_in;
   logic signed [CS_W-1:0]    s_ff, s_in;
   logic signed [Z_W-1:0]     z_ff, z_in;
   logic [1:0]                q_ff, q_in;
   logic [ITER_W-1:0]         iter_ff, iter_in;
   logic signed [CS_W-1:0]    cos_ff, cos_in;
   logic signed [CS_W-1:0]    sin_ff, sin_in;
   logic signed [UPD_W-1:0]   rnd_ff, rnd_in;
   logic [95:0]               rsp_data_ff, rsp_data_in;

   // input fields
   tick_type  left_ticks;
   tick_type  right_ticks;
   angle_type heading_set;
   logic [OP_W-1:0] operation;

   // shared multiplier
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;

   // helpers
   angle_type               shifted;
   logic signed [CS_W-1:0]  sh_c, sh_s;
   logic signed [Z_W-1:0]   atan_val;
   logic signed [PROD_W-1:0] rnd_d_sum, rnd_r_sum;
   logic signed [PROD_W-1:0] rnd_d_shf, rnd_r_shf;
   logic signed [UPD_W-1:0] upd_base, upd_diff;
   pos_type                 upd_sat;

   assign left_ticks  = tick_type'(req_tdata[15:0]);
   assign right_ticks = tick_type'(req_tdata[31:16]);
   assign heading_set = req_tdata[63:32];
   assign operation   = req_tuser;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // operand selection of the one multiplier
   always_comb begin
      unique case (state_ff)
         ST_HEAD: begin
            mul_a = MUL_W'(diff_ff);
            mul_b = MUL_W'($signed({1'b0, apt_ff}));
         end
         ST_DIST: begin
            mul_a = MUL_W'(sum_ff);
            mul_b = MUL_W'($signed({1'b0, dpt_ff}));
         end
         ST_MULX: begin
            mul_a = d_ff;
            mul_b = cos_ff[MUL_W-1:0];
         end
         ST_MULY: begin
            mul_a = d_ff;
            mul_b = sin_ff[MUL_W-1:0];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // round to nearest, ties away from zero: (p + half - neg) >>> shift
   assign rnd_d_sum = prod_ff + PROD_W'(1 << (D_SHIFT - 1)) - PROD_W'(prod_ff[PROD_W-1]);
   assign rnd_d_shf = rnd_d_sum >>> D_SHIFT;
   assign rnd_r_sum = prod_ff + PROD_W'(1 << (ROT_SHIFT - 1)) - PROD_W'(prod_ff[PROD_W-1]);
   assign rnd_r_shf = rnd_r_sum >>> ROT_SHIFT;

   // cordic micro-rotation
   assign sh_c     = c_ff >>> iter_ff;
   assign sh_s     = s_ff >>> iter_ff;
   assign atan_val = Z_W'(atan_lookup(ATAN_AW'(iter_ff)));

   // quadrant split of the updated heading
   assign shifted = heading_ff + angle_type'(32'h2000_0000);

   // saturating position update, x or y by state
   assign upd_base = (state_ff == ST_UPDX) ? UPD_W'(pos_x_ff) : UPD_W'(pos_y_ff);
   assign upd_diff = upd_base - rnd_ff;
   always_comb begin
      priority if (upd_diff > UPD_W'(32'sh7FFF_FFFF)) begin
         upd_sat = 32'sh7FFF_FFFF;
      end else if (upd_diff < -UPD_W'(33'sh0_8000_0000)) begin
         upd_sat = 32'sh8000_0000;
      end else begin
         upd_sat = upd_diff[POS_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      apt_in       = apt_ff;
      dpt_in       = dpt_ff;
      heading_in   = heading_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      diff_in      = diff_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      d_in         = d_ff;
      c_in         = c_ff;
      s_in         = s_ff;
      z_in         = z_ff;
      q_in         = q_ff;
      iter_in      = iter_ff;
      cos_in       = cos_ff;
      sin_in       = sin_ff;
      rnd_in       = rnd_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr_en) begin
         unique case (csr_index)
            REG_ANGLE_PER_TICK:    apt_in = csr_wr_data;
            REG_DISTANCE_PER_TICK: dpt_in = csr_wr_data;
            default:               apt_in = apt_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (operation == OP_CORRECTION) begin
                  heading_in = heading_set;
               end else begin
                  diff_in  = (TICK_W+1)'(left_ticks) - (TICK_W+1)'(right_ticks);
                  sum_in   = (TICK_W+1)'(left_ticks) + (TICK_W+1)'(right_ticks);
                  state_in = ST_HEAD;
               end
            end
         end
         ST_HEAD: begin
            prod_in  = mul_p;
            state_in = ST_DIST;
         end
         ST_DIST: begin
            // low bits only: the heading wraps modulo a full turn
            heading_in = heading_ff + prod_ff[ANGLE_W-1:0];
            prod_in    = mul_p;
            state_in   = ST_INIT;
         end
         ST_INIT: begin
            d_in     = rnd_d_shf[D_W-1:0];
            q_in     = shifted[31:30];
            // residual angle in [-pi/4, pi/4)
            z_in     = Z_W'($signed({~shifted[29], shifted[28:0]}));
            c_in     = CORDIC_GAIN;
            s_in     = '0;
            iter_in  = '0;
            state_in = ST_ITER;
         end
         ST_ITER: begin
            if (!z_ff[Z_W-1]) begin
               c_in = c_ff - sh_s;
               s_in = s_ff + sh_c;
               z_in = z_ff - atan_val;
            end else begin
               c_in = c_ff + sh_s;
               s_in = s_ff - sh_c;
               z_in = z_ff + atan_val;
            end
            iter_in = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_LAST) begin
               state_in = ST_ROT;
            end
         end
         ST_ROT: begin
            unique case (q_ff)
               2'd0: begin cos_in = c_ff;  sin_in = s_ff;  end
               2'd1: begin cos_in = -s_ff; sin_in = c_ff;  end
               2'd2: begin cos_in = -c_ff; sin_in = -s_ff; end
               default: begin cos_in = s_ff; sin_in = -c_ff; end
            endcase
            state_in = ST_MULX;
         end
         ST_MULX: begin
            prod_in  = mul_p;
            state_in = ST_RNDX;
         end
         ST_RNDX: begin
            rnd_in   = rnd_r_shf[UPD_W-1:0];
            state_in = ST_UPDX;
         end
         ST_UPDX: begin
            pos_x_in = upd_sat;
            state_in = ST_MULY;
         end
         ST_MULY: begin
            prod_in  = mul_p;
            state_in = ST_RNDY;
         end
         ST_RNDY: begin
            rnd_in   = rnd_r_shf[UPD_W-1:0];
            state_in = ST_UPDY;
         end
         ST_UPDY: begin
            pos_y_in = upd_sat;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {heading_ff, pos_y_ff, pos_x_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state, configuration registers and pose
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         apt_ff       <= '0;
         dpt_ff       <= '0;
         heading_ff   <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         apt_ff       <= apt_in;
         dpt_ff       <= dpt_in;
         heading_ff   <= heading_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      diff_ff     <= diff_in;
      sum_ff      <= sum_in;
      prod_ff     <= prod_in;
      d_ff        <= d_in;
      c_ff        <= c_in;
      s_ff        <= s_in;
      z_ff        <= z_in;
      q_ff        <= q_in;
      iter_ff     <= iter_in;
      cos_ff      <= cos_in;
      sin_ff      <= sin_in;
      rnd_ff      <= rnd_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

// ----- bench/tb_differential_drive_odometry.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_differential_drive_odometry: self-checking bench of the odometry block
// streams encoder and heading-correction items under bursty input and a
// stalling receiver, predicts every pose with a bit-exact fixed-point cordic
// model and compares x, y and heading of each returned pose in order
// ----------------------------------------------------------------------------
module tb_differential_drive_odometry;
   import ddo_pkg::*;

   localparam int  RESET_CYCLES   = 11;
   localparam int  SETTLE_CYCLES  = 50;     // a bit over the time an encoder item spends in the block
   localparam int  LONG_HOLD      = 400;    // receiver hold-off to back up the block
   localparam int  WATCHDOG_LIMIT = 4000;   // cycles with no item moving
   localparam int  PHASE_ITEMS    = 90;
   localparam int  ROT_STEPS      = CORDIC_ITER_DEFAULT;
   localparam int  STEP_SHIFT     = 9;      // q0.24 tick scale to q16.16 metres
   localparam int  UNIT_SHIFT     = 30;     // q2.30 cos and sin
   localparam longint UNIT_GAIN   = 64'sd652032874;
   localparam longint POS_HI      = 64'sd2147483647;
   localparam longint POS_LO      = -64'sd2147483648;
   localparam cfg_type CFG_MAX    = 24'hFF_FFFF;

   typedef enum logic [1:0] {QUAD_EAST, QUAD_NORTH, QUAD_WEST, QUAD_SOUTH} quadrant_e;

   // one input item; the last three fields line up with req_tdata
   typedef struct packed {
      logic [OP_W-1:0] op;
      angle_type       heading_set;
      tick_type        right;
      tick_type        left;
   } wheel_item;

   // one pose item, pos_x in the low bits as on rsp_tdata
   typedef struct packed {
      angle_type heading;
      pos_type   pos_y;
      pos_type   pos_x;
   } pose_rec;

   // arctangent of 2^-i as a binary angle
   angle_type arctan_steps [0:31] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;      // left_ticks, right_ticks, heading_set
   logic [0:0]  req_tuser = '0;      // operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;           // pos_x, pos_y, heading_out
   logic        csr_wr_en = 1'b0;
   cfg_idx_type csr_index = '0;
   cfg_type     csr_wr_data = '0;

   // items waiting to be sent and poses waiting to come back
   wheel_item pending_items[$];
   pose_rec   expected_poses[$];

   // tracked state of the block
   angle_type heading_track = '0;
   pos_type   pos_x_track = '0;
   pos_type   pos_y_track = '0;
   cfg_type   angle_step_reg = '0;
   cfg_type   dist_step_reg = '0;

   // run statistics
   int mismatch_count = 0;
   int items_accepted = 0;
   int corrections_seen = 0;
   int poses_checked = 0;
   int saturated_poses = 0;
   int settings_count = 0;

   bit hold_off_request = 1'b0;

   differential_drive_odometry dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------------
   // pose prediction
   // ------------------------------------------------------------------------

   // divide by 2^sh, round half away from zero
   function automatic longint round_away(input longint v, input int sh);
      logic [63:0] mag;
      mag = (v < 0) ? 64'(-v) : 64'(v);
      mag = (mag + (64'd1 << (sh - 1))) >> sh;
      return (v < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic pos_type clamp_pos(input longint v);
      if (v > POS_HI) return pos_type'(POS_HI);
      if (v < POS_LO) return pos_type'(POS_LO);
      return pos_type'(v);
   endfunction

   // rotation-mode cordic: cos and sin of a binary angle in q2.30
   function automatic void unit_vector(input angle_type ang, output longint cos_v,
                                       output longint sin_v);
      angle_type turned;
      longint    c, s, z, dc, ds;
      turned = ang + 32'h2000_0000;
      // residual angle in [-pi/4, pi/4), the top two bits pick the quadrant
      z = longint'(turned[29:0]) - 64'sh2000_0000;
      c = UNIT_GAIN;
      s = 0;
      for (int i = 0; i < ROT_STEPS; i++) begin
         dc = s >>> i;
         ds = c >>> i;
         if (z >= 0) begin
            c -= dc;
            s += ds;
            z -= longint'(arctan_steps[i]);
         end else begin
            c += dc;
            s -= ds;
            z += longint'(arctan_steps[i]);
         end
      end
      case (quadrant_e'(turned[31:30]))
         QUAD_EAST: begin
            cos_v = c;
            sin_v = s;
         end
         QUAD_NORTH: begin
            cos_v = -s;
            sin_v = c;
         end
         QUAD_WEST: begin
            cos_v = -c;
            sin_v = -s;
         end
         default: begin
            cos_v = s;
            sin_v = -c;
         end
      endcase
   endfunction

   // apply one encoder item to the tracked pose and return the new pose
   function automatic pose_rec advance_pose(input tick_type left, input tick_type right);
      longint  spin, step, cos_v, sin_v;
      pose_rec p;
      // heading wraps as a binary angle, only the low 32 bits matter
      spin = (longint'(left) - longint'(right)) * longint'(angle_step_reg);
      heading_track = heading_track + spin[31:0];
      step = round_away((longint'(left) + longint'(right)) * longint'(dist_step_reg),
                        STEP_SHIFT);
      unit_vector(heading_track, cos_v, sin_v);
      pos_x_track = clamp_pos(longint'(pos_x_track) - round_away(step * cos_v, UNIT_SHIFT));
      pos_y_track = clamp_pos(longint'(pos_y_track) - round_away(step * sin_v, UNIT_SHIFT));
      p.heading = heading_track;
      p.pos_x   = pos_x_track;
      p.pos_y   = pos_y_track;
      return p;
   endfunction

   // ------------------------------------------------------------------------
   // sender: bursts of random length with random gaps, fed from pending_items
   // ------------------------------------------------------------------------
   int gap_left = 0;
   int burst_left = 0;

   always @(posedge clock) begin : sender
      bit took;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
         burst_left = 0;
      end else begin
         took = req_tvalid && req_tready;
         if (took) begin
            void'(pending_items.pop_front());
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               // start a new burst, often with no gap at all
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            end
         end
         if (req_tvalid && !took) begin
            // item still offered, hold it
         end else if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {pending_items[0].heading_set, pending_items[0].right,
                           pending_items[0].left};
            req_tuser  <= pending_items[0].op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // receiver: rotating random ready mask, reloaded at the start of each window, with one
   // long hold-off on request so the block backs up and stalls its input
   // ------------------------------------------------------------------------
   int          hold_left = 0;
   int          pattern_age = 0;
   logic [31:0] ready_mask = '1;

   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_off_request) begin
         hold_off_request = 1'b0;
         hold_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         if (pattern_age == 0) begin
            // a quarter of the windows never stall
            ready_mask = ($urandom_range(0, 3) == 0) ? '1 : $urandom;
            pattern_age = 48;
         end
         pattern_age--;
         rsp_tready <= ready_mask[0];
         ready_mask = {ready_mask[0], ready_mask[31:1]};
      end
   end

   // ------------------------------------------------------------------------
   // monitor: check poses first, then predict from the item taken this edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      pose_rec   got, want;
      wheel_item taken;
      if (reset) begin
         heading_track  = '0;
         pos_x_track    = '0;
         pos_y_track    = '0;
         angle_step_reg = '0;
         dist_step_reg  = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_poses.size() == 0) begin
               $error("unexpected pose item: pos_x %0d pos_y %0d heading %h",
                      got.pos_x, got.pos_y, got.heading);
               mismatch_count++;
            end else begin
               want = expected_poses.pop_front();
               poses_checked++;
               if (got.pos_x !== want.pos_x) begin
                  $error("pos_x: expected %0d, actual %0d", want.pos_x, got.pos_x);
                  mismatch_count++;
               end
               if (got.pos_y !== want.pos_y) begin
                  $error("pos_y: expected %0d, actual %0d", want.pos_y, got.pos_y);
                  mismatch_count++;
               end
               if (got.heading !== want.heading) begin
                  $error("heading_out: expected %h, actual %h", want.heading, got.heading);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            taken = {req_tuser, req_tdata};
            items_accepted++;
            if (taken.op == OP_CORRECTION) begin
               // correction replaces the heading and returns nothing
               heading_track = taken.heading_set;
               corrections_seen++;
            end else begin
               want = advance_pose(taken.left, taken.right);
               if (longint'(want.pos_x) inside {POS_HI, POS_LO} ||
                   longint'(want.pos_y) inside {POS_HI, POS_LO})
                  saturated_poses++;
               expected_poses.push_back(want);
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               REG_ANGLE_PER_TICK:    angle_step_reg = csr_wr_data;
               REG_DISTANCE_PER_TICK: dist_step_reg  = csr_wr_data;
               default: ;
            endcase
         end
      end
   end

   // watchdog: ends the run when no item moves for too long
   int idle_cycles = 0;

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   task automatic write_reg(input cfg_idx_type idx, input cfg_type val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // only called with the block idle
   task automatic set_registers(input cfg_type angle_step, input cfg_type dist_step);
      write_reg(REG_ANGLE_PER_TICK, angle_step);
      write_reg(REG_DISTANCE_PER_TICK, dist_step);
      settings_count++;
      @(negedge clock);
   endtask

   // waits until every item is sent and every pose is back, then lets the block settle
   task automatic settle();
      while (pending_items.size() != 0 || expected_poses.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic push_encoder(input tick_type left, input tick_type right);
      wheel_item it;
      it = '{op: OP_ENCODER, heading_set: '0, right: right, left: left};
      pending_items.push_back(it);
   endtask

   task automatic push_correction(input angle_type h);
      wheel_item it;
      it = '{op: OP_CORRECTION, heading_set: h, right: '0, left: '0};
      pending_items.push_back(it);
   endtask

   function automatic tick_type random_ticks();
      case ($urandom_range(0, 5))
         0: return tick_type'($urandom);
         1: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
         default: return tick_type'(int'($urandom_range(0, 400)) - 200);
      endcase
   endfunction

   // eighth-turn boundaries or the angle just below one, else any angle
   function automatic angle_type random_heading();
      angle_type h;
      if ($urandom_range(0, 2) == 0) begin
         h = angle_type'($urandom_range(0, 7)) << 29;
         h = h - angle_type'($urandom_range(0, 1));
      end else begin
         h = $urandom;
      end
      return h;
   endfunction

   task automatic random_phase(input cfg_type angle_step, input cfg_type dist_step,
                               input bit long_stall);
      wheel_item it;
      set_registers(angle_step, dist_step);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         it.op          = ($urandom_range(0, 4) == 0) ? OP_CORRECTION : OP_ENCODER;
         it.left        = random_ticks();
         it.right       = random_ticks();
         it.heading_set = random_heading();
         pending_items.push_back(it);
      end
      if (long_stall) hold_off_request = 1'b1;
      settle();
   endtask

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero registers: encoder items leave pose and heading put
      set_registers('0, '0);
      push_encoder(16'sh7FFF, 16'sh7FFF);
      push_encoder(16'sh8000, 16'sh7FFF);
      push_correction(32'h4000_0000);
      push_encoder(16'sd100, -16'sd100);
      settle();

      // moderate scale: tick extremes and quadrant edges
      set_registers(24'h0A_3D71, 24'h01_0000);
      push_encoder(16'sd0, 16'sd0);
      push_encoder(16'sh7FFF, 16'sh7FFF);
      push_encoder(16'sh8000, 16'sh8000);
      push_encoder(16'sh7FFF, 16'sh8000);
      push_encoder(16'sh8000, 16'sh7FFF);
      push_correction(32'hFFFF_FFFF);
      push_encoder(16'sd1, 16'sd1);
      push_correction(32'h2000_0000);
      push_encoder(16'sd10, 16'sd10);
      push_correction(32'h1FFF_FFFF);
      push_encoder(16'sd10, 16'sd10);
      push_correction(32'hC000_0000);
      push_encoder(-16'sd5, 16'sd7);
      settle();

      // full scale: heading wrap, then saturate x low and x high
      set_registers(CFG_MAX, CFG_MAX);
      push_encoder(16'sh7FFF, 16'sh8000);
      push_correction(32'h0);
      push_encoder(16'sh7FFF, 16'sh7FFF);
      push_encoder(16'sh7FFF, 16'sh7FFF);
      push_correction(32'h8000_0000);
      push_encoder(16'sh7FFF, 16'sh7FFF);
      push_encoder(16'sh7FFF, 16'sh7FFF);
      push_encoder(16'sh7FFF, 16'sh7FFF);
      push_encoder(16'sh8000, 16'sh8000);
      settle();

      // random items over a spread of register settings
      random_phase(cfg_type'($urandom_range(0, CFG_MAX)),
                   cfg_type'($urandom_range(0, CFG_MAX)), 1'b0);
      random_phase(CFG_MAX, cfg_type'($urandom_range(1, 4095)), 1'b1);
      random_phase(cfg_type'($urandom_range(1, 4095)), CFG_MAX, 1'b0);
      random_phase('0, cfg_type'($urandom_range(0, CFG_MAX)), 1'b0);
      random_phase(cfg_type'($urandom_range(0, CFG_MAX)), '0, 1'b0);
      random_phase(cfg_type'($urandom_range(0, CFG_MAX)),
                   cfg_type'($urandom_range(0, CFG_MAX)), 1'b0);

      $display("covered %0d items (%0d heading corrections) over %0d register settings",
               items_accepted, corrections_seen, settings_count);
      $display("checked %0d poses, %0d of them at a saturated position limit",
               poses_checked, saturated_poses);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/ddo_pkg.sv
sv/differential_drive_odometry.sv
bench/tb_differential_drive_odometry.sv
